[rtl/core/cma_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants and types of the complex moving average.
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int WIN_W       = 11;
   localparam int SCALE_W     = 18;
   localparam int FRAC_BITS   = 16;
   localparam int FIFO_DEPTH  = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WIN_W-1:0]          WIN_RESET      = 11'd1;
   localparam logic signed [SCALE_W-1:0] SCALE_RE_RESET = 18'sd65536;
   localparam logic signed [SCALE_W-1:0] SCALE_IM_RESET = 18'sd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW   = 2'd0,
      CSR_SCALE_RE = 2'd1,
      CSR_SCALE_IM = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

[rtl/core/cma_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_req_if
// Sample channel: one complex sample per beat.
// ----------------------------------------------------------------------------
interface cma_req_if #(
   parameter int W = 16
) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] sample_re;
   logic signed [W-1:0] sample_im;

   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface
`default_nettype wire

[rtl/core/cma_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_rsp_if
// Result channel: one scaled window sum per beat.
// ----------------------------------------------------------------------------
interface cma_rsp_if #(
   parameter int W = 16
) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] avg_re;
   logic signed [W-1:0] avg_im;
   logic                clipped;

   modport source (output valid, output avg_re, output avg_im, output clipped, input ready);
   modport sink   (input valid, input avg_re, input avg_im, input clipped, output ready);
endinterface
`default_nettype wire

[rtl/core/complex_moving_average.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_moving_average
// Boxcar sum of the last L complex samples times a complex Q2.16 scale,
// floored and saturated per part.
// ----------------------------------------------------------------------------
// req_bus carries one I/Q sample per beat, rsp_bus one result per sample, in
// order. csr_we/csr_index/csr_wdata write window_length (0), scale_re (1) and
// scale_im (2); other indexes are ignored.
// A result passes the input, sum, product and output registers and the queue.
// Throughput: one sample per cycle while req_bus.ready is high; the history RAM
// is read and written once per sample, the running sums update in one add per cycle.
// Up to 8 results are held in an output queue; req_bus.ready drops when the
// samples in flight and queued reach 8, so a stalled receiver back-pressures
// the sample side without loss.
// Writing window_length re-sums the most recent L stored samples from the
// RAM, one per cycle: req_bus.ready is low in the write cycle and until the
// last sample read by the sweep has been added to the sums.
// Reset: synchronous; history reads as zero (tracked by a fill count, no
// clearing pass), sums zero, L = 1, scale = 1.0 + 0j. Ready the cycle after.
// ----------------------------------------------------------------------------
module complex_moving_average import cma_pkg::*; #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   cma_req_if.sink                       req_bus,
   cma_rsp_if.source                     rsp_bus,
   input  wire logic                     csr_we,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [SCALE_W-1:0]       csr_wdata
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int RES_W = 2 * SAMPLE_BITS + 1;
   localparam int CRW   = $clog2(FIFO_DEPTH + 1);

   logic signed [SCALE_W-1:0]     scale_re_ff, scale_im_ff;
   logic [CRW-1:0]                cred_ff, cred_in;
   logic                          in_beat, out_beat, win_we, win_busy;
   logic                          sum_valid;
   logic signed [SUM_W-1:0]       sum_re, sum_im;
   logic                          res_valid;
   logic signed [SAMPLE_BITS-1:0] res_re, res_im;
   logic                          res_clip;
   logic [RES_W-1:0]              q_data;

   assign win_we   = csr_we && (csr_index == CSR_WINDOW);
   assign in_beat  = req_bus.valid & req_bus.ready;
   assign out_beat = rsp_bus.valid & rsp_bus.ready;
   assign cred_in  = cred_ff + CRW'(in_beat) - CRW'(out_beat);

   assign req_bus.ready = !win_busy && (cred_ff < CRW'(FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_re_ff <= SCALE_RE_RESET;
         scale_im_ff <= SCALE_IM_RESET;
         cred_ff     <= '0;
      end else begin
         cred_ff <= cred_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SCALE_RE: begin
                  scale_re_ff <= $signed(csr_wdata);
               end
               CSR_SCALE_IM: begin
                  scale_im_ff <= $signed(csr_wdata);
               end
               default: begin
               end
            endcase
         end
      end
   end

   cma_window #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .win_we    (win_we),
      .win_data  (csr_wdata[WIN_W-1:0]),
      .in_beat   (in_beat),
      .in_re     (req_bus.sample_re),
      .in_im     (req_bus.sample_im),
      .busy      (win_busy),
      .sum_valid (sum_valid),
      .sum_re    (sum_re),
      .sum_im    (sum_im)
   );

   cma_scale #(
      .SUM_W       (SUM_W),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .sum_re    (sum_re),
      .sum_im    (sum_im),
      .scale_re  (scale_re_ff),
      .scale_im  (scale_im_ff),
      .out_valid (res_valid),
      .avg_re    (res_re),
      .avg_im    (res_im),
      .clipped   (res_clip)
   );

   cma_rsp_fifo #(
      .W (RES_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (res_valid),
      .wr_data  ({res_re, res_im, res_clip}),
      .rd_valid (rsp_bus.valid),
      .rd_ready (rsp_bus.ready),
      .rd_data  (q_data)
   );

   assign rsp_bus.avg_re  = q_data[RES_W-1:SAMPLE_BITS+1];
   assign rsp_bus.avg_im  = q_data[SAMPLE_BITS:1];
   assign rsp_bus.clipped = q_data[0];

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cred_ff <= CRW'(FIFO_DEPTH))
      else $error("outstanding results exceed queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (cred_ff != '0))
      else $error("result offered with no sample outstanding");

   a_resum_blocks: assert property (@(posedge clock) disable iff (reset)
      win_we |=> !req_bus.ready)
      else $error("sample accepted during window re-sum");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (cred_ff != '0))
      else $error("pipeline result with no credit held");
`endif

endmodule
`default_nettype wire

[rtl/core/cma_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/core/cma_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_window
// Sample history ring and running I/Q window sums, with a re-sum sweep over
// the history when the window length changes.
// ----------------------------------------------------------------------------
module cma_window import cma_pkg::*; #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int AW         = $clog2(MAX_WINDOW),
   localparam int SUM_W      = SAMPLE_BITS + AW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          win_we,
   input  wire logic        [WIN_W-1:0]       win_data,
   input  wire logic                          in_beat,
   input  wire logic signed [SAMPLE_BITS-1:0] in_re,
   input  wire logic signed [SAMPLE_BITS-1:0] in_im,
   output logic                               busy,
   output logic                               sum_valid,
   output logic signed      [SUM_W-1:0]       sum_re,
   output logic signed      [SUM_W-1:0]       sum_im
);

   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int DW = LW + 1;
   localparam int XW = SUM_W - SAMPLE_BITS;

   function automatic logic [LW-1:0] eff_len(input logic [WIN_W-1:0] w);
      logic [LW-1:0] n;
      if (w == '0) begin
         n = LW'(1);
      end else if (32'(w) > 32'(MAX_WINDOW)) begin
         n = LW'(MAX_WINDOW);
      end else begin
         n = LW'(w);
      end
      return n;
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
      logic [AW-1:0] r;
      if (s == '0) begin
         r = AW'(MAX_WINDOW - 1);
      end else begin
         r = s - AW'(1);
      end
      return r;
   endfunction

   logic [WIN_W-1:0]             win_ff;
   logic [AW-1:0]                wslot_ff, wslot_in;
   logic [LW-1:0]                fill_ff, fill_in;
   logic [LW-1:0]                sweep_left_ff, sweep_left_in;
   logic [AW-1:0]                sweep_idx_ff, sweep_idx_in;
   logic                         sweep_rd_ff, sweep_rd_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic                         s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_re_ff, s1_im_ff;
   logic                         sum_valid_ff;
   logic signed [SUM_W-1:0]      sum_re_ff, sum_re_in;
   logic signed [SUM_W-1:0]      sum_im_ff, sum_im_in;

   logic [LW-1:0]                win_len;
   logic [DW-1:0]                old_raw, old_wrap;
   logic                         sweep_active;
   logic [AW-1:0]                raddr;
   logic [2*SAMPLE_BITS-1:0]     rdata;
   logic [SAMPLE_BITS-1:0]       old_re, old_im;
   logic signed [SUM_W-1:0]      old_re_x, old_im_x, s1_re_x, s1_im_x;

   cma_ram #(
      .WIDTH (2 * SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_hist (
      .clock (clock),
      .we    (in_beat),
      .waddr (wslot_ff),
      .wdata ({in_re, in_im}),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      win_len      = eff_len(win_ff);
      old_raw      = DW'(wslot_ff) - DW'(win_len);
      old_wrap     = old_raw[DW-1] ? old_raw + DW'(MAX_WINDOW) : old_raw;
      sweep_active = (sweep_left_ff != '0);
      if (sweep_active) begin
         raddr    = sweep_idx_ff;
         rd_ok_in = DW'(sweep_idx_ff) < DW'(fill_ff);
      end else begin
         raddr    = old_wrap[AW-1:0];
         rd_ok_in = old_wrap < DW'(fill_ff);
      end
   end

   // slots never written since reset read as zero
   always_comb begin
      old_re   = rd_ok_ff ? rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
      old_im   = rd_ok_ff ? rdata[SAMPLE_BITS-1:0] : '0;
      old_re_x = {{XW{old_re[SAMPLE_BITS-1]}}, old_re};
      old_im_x = {{XW{old_im[SAMPLE_BITS-1]}}, old_im};
      s1_re_x  = {{XW{s1_re_ff[SAMPLE_BITS-1]}}, s1_re_ff};
      s1_im_x  = {{XW{s1_im_ff[SAMPLE_BITS-1]}}, s1_im_ff};
   end

   always_comb begin
      wslot_in = wslot_ff;
      fill_in  = fill_ff;
      if (in_beat) begin
         wslot_in = (wslot_ff == AW'(MAX_WINDOW - 1)) ? '0 : wslot_ff + AW'(1);
         if (fill_ff != LW'(MAX_WINDOW)) begin
            fill_in = fill_ff + LW'(1);
         end
      end
   end

   always_comb begin
      sweep_left_in = sweep_left_ff;
      sweep_idx_in  = sweep_idx_ff;
      sweep_rd_in   = 1'b0;
      if (win_we) begin
         sweep_left_in = eff_len(win_data);
         sweep_idx_in  = slot_dec(wslot_ff);
      end else if (sweep_active) begin
         sweep_left_in = sweep_left_ff - LW'(1);
         sweep_idx_in  = slot_dec(sweep_idx_ff);
         sweep_rd_in   = 1'b1;
      end
   end

   always_comb begin
      sum_re_in = sum_re_ff;
      sum_im_in = sum_im_ff;
      if (win_we) begin
         sum_re_in = '0;
         sum_im_in = '0;
      end else if (sweep_rd_ff) begin
         sum_re_in = sum_re_ff + old_re_x;
         sum_im_in = sum_im_ff + old_im_x;
      end else if (s1_valid_ff) begin
         sum_re_in = sum_re_ff + s1_re_x - old_re_x;
         sum_im_in = sum_im_ff + s1_im_x - old_im_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= WIN_RESET;
         wslot_ff      <= '0;
         fill_ff       <= '0;
         sweep_left_ff <= '0;
         sweep_idx_ff  <= '0;
         sweep_rd_ff   <= 1'b0;
         rd_ok_ff      <= 1'b0;
         s1_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
         sum_re_ff     <= '0;
         sum_im_ff     <= '0;
      end else begin
         if (win_we) begin
            win_ff <= win_data;
         end
         wslot_ff      <= wslot_in;
         fill_ff       <= fill_in;
         sweep_left_ff <= sweep_left_in;
         sweep_idx_ff  <= sweep_idx_in;
         sweep_rd_ff   <= sweep_rd_in;
         rd_ok_ff      <= rd_ok_in;
         s1_valid_ff   <= in_beat;
         sum_valid_ff  <= s1_valid_ff;
         sum_re_ff     <= sum_re_in;
         sum_im_ff     <= sum_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_beat) begin
         s1_re_ff <= in_re;
         s1_im_ff <= in_im;
      end
   end

   assign busy      = win_we | sweep_active | sweep_rd_ff;
   assign sum_valid = sum_valid_ff;
   assign sum_re    = sum_re_ff;
   assign sum_im    = sum_im_ff;

endmodule
`default_nettype wire

[rtl/core/cma_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_scale
// Complex scale of the window sums: products, floor from Q2.16, saturation.
// ----------------------------------------------------------------------------
module cma_scale import cma_pkg::*; #(
   parameter int SUM_W       = 26,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [SUM_W-1:0]       sum_re,
   input  wire logic signed [SUM_W-1:0]       sum_im,
   input  wire logic signed [SCALE_W-1:0]     scale_re,
   input  wire logic signed [SCALE_W-1:0]     scale_im,
   output logic                               out_valid,
   output logic signed      [SAMPLE_BITS-1:0] avg_re,
   output logic signed      [SAMPLE_BITS-1:0] avg_im,
   output logic                               clipped
);

   localparam int PW = SUM_W + SCALE_W;
   localparam int SW = PW + 1;
   localparam int QW = SW - FRAC_BITS;

   function automatic logic [SAMPLE_BITS:0] saturate(input logic [QW-1:0] q);
      logic [QW-SAMPLE_BITS:0] top;
      logic [SAMPLE_BITS:0]    r;
      top = q[QW-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         r = {1'b0, q[SAMPLE_BITS-1:0]};
      end else if (q[QW-1]) begin
         r = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   logic                 pv_ff;
   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic [SW-1:0]        p_re, p_im;
   logic [SAMPLE_BITS:0] sat_re, sat_im;
   logic                 out_valid_ff;
   logic [SAMPLE_BITS-1:0] avg_re_ff, avg_im_ff;
   logic                 clipped_ff;

   always_comb begin
      p_re   = {rr_ff[PW-1], rr_ff} - {ii_ff[PW-1], ii_ff};
      p_im   = {ri_ff[PW-1], ri_ff} + {ir_ff[PW-1], ir_ff};
      sat_re = saturate(p_re[SW-1:FRAC_BITS]);
      sat_im = saturate(p_im[SW-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pv_ff        <= in_valid;
         out_valid_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff      <= sum_re * scale_re;
      ii_ff      <= sum_im * scale_im;
      ri_ff      <= sum_re * scale_im;
      ir_ff      <= sum_im * scale_re;
      avg_re_ff  <= sat_re[SAMPLE_BITS-1:0];
      avg_im_ff  <= sat_im[SAMPLE_BITS-1:0];
      clipped_ff <= sat_re[SAMPLE_BITS] | sat_im[SAMPLE_BITS];
   end

   assign out_valid = out_valid_ff;
   assign avg_re    = avg_re_ff;
   assign avg_im    = avg_im_ff;
   assign clipped   = clipped_ff;

endmodule
`default_nettype wire

[rtl/core/cma_rsp_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cma_rsp_fifo
// Result queue between the arithmetic pipeline and the result channel.
// ----------------------------------------------------------------------------
module cma_rsp_fifo import cma_pkg::*; #(
   parameter int W = 33
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_en,
   input  wire logic [W-1:0] wr_data,
   output logic              rd_valid,
   input  wire logic         rd_ready,
   output logic      [W-1:0] rd_data
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [W-1:0]     store_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] head_ff, tail_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rd_beat;

   assign rd_beat  = rd_valid & rd_ready;
   assign count_in = count_ff + CNT_W'(wr_en) - CNT_W'(rd_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) begin
            tail_ff <= (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         end
         if (rd_beat) begin
            head_ff <= (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[tail_ff] <= wr_data;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_data  = store_ff[head_ff];

endmodule
`default_nettype wire
